// ===== design/trd_pkg.sv =====
`default_nettype none
package trd_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int OUT_FRAC_BITS   = 14;

	localparam int ANGLE_W = 16;
	localparam int TRIG_W  = 16;
	localparam int RATIO_W = 22;
	localparam int FLAG_W  = 4;

	localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 << ANGLE_FRAC_BITS);
	localparam logic [ANGLE_W-1:0] QUARTER   = ANGLE_W'(90 << ANGLE_FRAC_BITS);
	localparam logic [ANGLE_W-1:0] EIGHTH    = ANGLE_W'(45 << ANGLE_FRAC_BITS);

	localparam int OCT_W = 13;
	localparam int RAD_W = 27;
	localparam logic [RAD_W-1:0] DEG_TO_RAD = RAD_W'(74961321);

	// Q0.32 values; the unit needs one more bit
	localparam int Q_W    = 32;
	localparam int UNIT_W = Q_W + 1;
	localparam logic [UNIT_W-1:0] ONE_Q = UNIT_W'(1) << Q_W;

	// division of the powers x^3..x^6 by 6, 24, 120, 720
	localparam int NCDIV  = 4;
	localparam int RECIP_W = 33;
	localparam int PROD_W  = Q_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M [NCDIV] = '{
		RECIP_W'(64'd5726623061), RECIP_W'(64'd5726623061),
		RECIP_W'(64'd4581298449), RECIP_W'(64'd6108397932)};
	localparam int RECIP_SH [NCDIV] = '{35, 37, 39, 42};
	localparam logic [Q_W-1:0] RECIP_D [NCDIV] = '{
		Q_W'(6), Q_W'(24), Q_W'(120), Q_W'(720)};

	localparam int TRIG_MAG_W = TRIG_W - 1;
	localparam int TRIG_SH    = Q_W - OUT_FRAC_BITS;
	localparam logic [TRIG_MAG_W-1:0] TRIG_LIMIT = '1;

	// ratio divider
	localparam int Q_BITS    = RATIO_W - 1;
	localparam int OVF_SHIFT = Q_BITS - OUT_FRAC_BITS;
	localparam int DIV_STEPS = 3;
	localparam int DIV_STAGES = (Q_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam logic [Q_BITS-1:0] RATIO_LIMIT = '1;

	localparam int FRONT_STAGES = 11;
	localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;

	localparam int FLAG_TAN = 0;
	localparam int FLAG_CSC = 1;
	localparam int FLAG_SEC = 2;
	localparam int FLAG_COT = 3;

	typedef enum logic [1:0] {
		QUAD_1 = 2'd0,
		QUAD_2 = 2'd1,
		QUAD_3 = 2'd2,
		QUAD_4 = 2'd3
	} quad_t;

	typedef struct packed {
		logic                  sneg;
		logic                  cneg;
		logic [TRIG_MAG_W-1:0] sin_mag;
		logic [TRIG_MAG_W-1:0] cos_mag;
	} side_t;

endpackage
`default_nettype wire

// ===== design/trd_in_if.sv =====
`default_nettype none
interface trd_in_if import trd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle_degrees;

	modport source (output valid, output angle_degrees, input ready);
	modport sink (input valid, input angle_degrees, output ready);
endinterface
`default_nettype wire

// ===== design/trd_out_if.sv =====
`default_nettype none
interface trd_out_if import trd_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [TRIG_W-1:0]  sine_value;
	logic signed [TRIG_W-1:0]  cosine_value;
	logic signed [RATIO_W-1:0] tangent_value;
	logic signed [RATIO_W-1:0] cosecant_value;
	logic signed [RATIO_W-1:0] secant_value;
	logic signed [RATIO_W-1:0] cotangent_value;
	logic [FLAG_W-1:0]         saturation_flags;

	modport source (output valid, output sine_value, output cosine_value,
		output tangent_value, output cosecant_value, output secant_value,
		output cotangent_value, output saturation_flags, input ready);
	modport sink (input valid, input sine_value, input cosine_value,
		input tangent_value, input cosecant_value, input secant_value,
		input cotangent_value, input saturation_flags, output ready);
endinterface
`default_nettype wire

// ===== design/trd_div.sv =====
`default_nettype none
module trd_div import trd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [UNIT_W-1:0] num,
	input  wire logic [UNIT_W-1:0] den,
	output logic      [Q_BITS-1:0] quo,
	output logic                   ovf
);

	typedef struct packed {
		logic [UNIT_W-1:0] rem;
		logic [Q_BITS-1:0] acc;
		logic [UNIT_W-1:0] den;
		logic              ovf;
	} div_t;

	function automatic div_t div_step(div_t a);
		logic [UNIT_W:0] t;
		div_t r;
		r = a;
		t = {a.rem, a.acc[Q_BITS-1]};
		if (t >= {1'b0, a.den}) begin
			r.rem = UNIT_W'(t - {1'b0, a.den});
			r.acc = {a.acc[Q_BITS-2:0], 1'b1};
		end else begin
			r.rem = t[UNIT_W-1:0];
			r.acc = {a.acc[Q_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	div_t head;
	div_t stg_s [DIV_STAGES];
	div_t nxt [DIV_STAGES];

	// quotient of num<<OUT_FRAC_BITS overflows Q_BITS exactly when num >= den<<OVF_SHIFT
	always_comb begin
		head.ovf = {{OVF_SHIFT{1'b0}}, num} >= {den, {OVF_SHIFT{1'b0}}};
		head.rem = UNIT_W'(num >> OVF_SHIFT);
		head.acc = {num[OVF_SHIFT-1:0], {OUT_FRAC_BITS{1'b0}}};
		head.den = den;
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		always_comb begin
			nxt[i] = (i == 0) ? head : stg_s[(i == 0) ? 0 : i-1];
			for (int k = 0; k < DIV_STEPS; k++) begin
				if (i * DIV_STEPS + k < Q_BITS) begin
					nxt[i] = div_step(nxt[i]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i] <= nxt[i];
			end
		end
	end

	assign quo = stg_s[DIV_STAGES-1].acc;
	assign ovf = stg_s[DIV_STAGES-1].ovf;

endmodule
`default_nettype wire

// ===== design/trig_ratios_taylor_degrees.sv =====
// Channel  Dir  Interface    Fields
// angle    in   trd_in_if    angle_degrees
// ratios   out  trd_out_if   sine/cosine/tangent/cosecant/secant/cotangent, saturation_flags
//
// One angle is taken every cycle except while the pipeline holds.
// Eleven stages reduce the angle, build the powers with one 32x32 multiply per stage,
// divide by the series constants and form sine and cosine; seven stages of a
// restoring divider (three quotient bits each) give the four ratios; one output stage.
// The whole pipeline holds while a result waits at the output and the sink is not ready.
// Reset clears only the valid bits.
`default_nettype none
module trig_ratios_taylor_degrees import trd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	trd_in_if.sink    angle,
	trd_out_if.source ratios
);

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en          = !vld_q[PIPE_DEPTH-1] || ratios.ready;
	assign angle.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], angle.valid};
		end
	end

	// stage 1: reduce to one turn, fold into a quadrant and an octant
	logic [ANGLE_W-1:0] d_red, folded;
	quad_t              quad;
	logic [OCT_W-1:0]   octant;

	always_comb begin
		d_red = (angle.angle_degrees > FULL_TURN) ? angle.angle_degrees - FULL_TURN
			: angle.angle_degrees;
		priority if (d_red <= QUARTER) begin
			quad   = QUAD_1;
			folded = d_red;
		end else if (d_red <= ANGLE_W'(2 * QUARTER)) begin
			quad   = QUAD_2;
			folded = ANGLE_W'(2 * QUARTER) - d_red;
		end else if (d_red <= ANGLE_W'(3 * QUARTER)) begin
			quad   = QUAD_3;
			folded = d_red - ANGLE_W'(2 * QUARTER);
		end else begin
			quad   = QUAD_4;
			folded = FULL_TURN - d_red;
		end
		octant = (folded > EIGHTH) ? OCT_W'(QUARTER - folded) : OCT_W'(folded);
	end

	quad_t quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7, quad_s8;
	quad_t quad_s9, quad_s10;
	logic  swap_s1, swap_s2, swap_s3, swap_s4, swap_s5, swap_s6, swap_s7, swap_s8;
	logic  swap_s9, swap_s10;
	logic [OCT_W-1:0] octant_s1;

	// stages 2..7: radians and powers
	logic [OCT_W+RAD_W-1:0] rad_prod;
	logic [2*Q_W-1:0]       p2, p3, p4, p5, p6;
	logic [Q_W-1:0] x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9;
	logic [Q_W-1:0] x2_s3, x2_s4, x2_s5, x2_s6, x2_s7, x2_s8, x2_s9;
	logic [Q_W-1:0] x3_s4, x3_s5, x3_s6, x3_s7;
	logic [Q_W-1:0] x4_s5, x4_s6, x4_s7;
	logic [Q_W-1:0] x5_s6, x5_s7;
	logic [Q_W-1:0] x6_s7;

	assign rad_prod = OCT_W'(octant_s1) * (OCT_W+RAD_W)'(DEG_TO_RAD);
	assign p2 = {{Q_W{1'b0}}, x_s2} * {{Q_W{1'b0}}, x_s2};
	assign p3 = {{Q_W{1'b0}}, x2_s3} * {{Q_W{1'b0}}, x_s3};
	assign p4 = {{Q_W{1'b0}}, x3_s4} * {{Q_W{1'b0}}, x_s4};
	assign p5 = {{Q_W{1'b0}}, x4_s5} * {{Q_W{1'b0}}, x_s5};
	assign p6 = {{Q_W{1'b0}}, x5_s6} * {{Q_W{1'b0}}, x_s6};

	// stages 8..9: divide powers by series constants, reciprocal then correction
	logic [Q_W-1:0] pw7 [NCDIV];
	logic [Q_W-1:0] pw_s8 [NCDIV];
	logic [Q_W-1:0] q0_s8 [NCDIV];
	logic [Q_W-1:0] dq_s9 [NCDIV];
	logic [Q_W-1:0] q0 [NCDIV];
	logic [Q_W-1:0] dq [NCDIV];
	logic [PROD_W-1:0] rp [NCDIV];
	logic [Q_W-1:0] rem [NCDIV];

	assign pw7[0] = x3_s7;
	assign pw7[1] = x4_s7;
	assign pw7[2] = x5_s7;
	assign pw7[3] = x6_s7;

	always_comb begin
		for (int i = 0; i < NCDIV; i++) begin
			rp[i]  = PROD_W'(pw7[i]) * PROD_W'(RECIP_M[i]);
			q0[i]  = Q_W'(rp[i] >> RECIP_SH[i]);
			rem[i] = pw_s8[i] - Q_W'(q0_s8[i] * RECIP_D[i]);
			dq[i]  = q0_s8[i] + Q_W'(rem[i] >= RECIP_D[i]);
		end
	end

	// stage 10: series sums
	logic [UNIT_W-1:0] sp_s10, cp_s10;

	// stage 11: swap, round sine and cosine
	logic [UNIT_W-1:0] s_sel, c_sel;
	logic [UNIT_W-1:0] s_s11, c_s11;
	side_t             side_s11;
	side_t             side_n;

	function automatic logic [TRIG_MAG_W-1:0] to_trig(logic [UNIT_W-1:0] v);
		logic [UNIT_W:0] r;
		r = ({1'b0, v} + (UNIT_W+1)'(1 << (TRIG_SH - 1))) >> TRIG_SH;
		return (r > (UNIT_W+1)'(TRIG_LIMIT)) ? TRIG_LIMIT : r[TRIG_MAG_W-1:0];
	endfunction

	always_comb begin
		s_sel          = swap_s10 ? cp_s10 : sp_s10;
		c_sel          = swap_s10 ? sp_s10 : cp_s10;
		side_n.sneg    = (quad_s10 == QUAD_3) || (quad_s10 == QUAD_4);
		side_n.cneg    = (quad_s10 == QUAD_2) || (quad_s10 == QUAD_3);
		side_n.sin_mag = to_trig(s_sel);
		side_n.cos_mag = to_trig(c_sel);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1   <= quad;
			swap_s1   <= folded > EIGHTH;
			octant_s1 <= octant;

			quad_s2 <= quad_s1;  swap_s2 <= swap_s1;
			x_s2    <= rad_prod[ANGLE_FRAC_BITS +: Q_W];

			quad_s3 <= quad_s2;  swap_s3 <= swap_s2;
			x_s3    <= x_s2;     x2_s3   <= p2[2*Q_W-1:Q_W];

			quad_s4 <= quad_s3;  swap_s4 <= swap_s3;
			x_s4    <= x_s3;     x2_s4   <= x2_s3;
			x3_s4   <= p3[2*Q_W-1:Q_W];

			quad_s5 <= quad_s4;  swap_s5 <= swap_s4;
			x_s5    <= x_s4;     x2_s5   <= x2_s4;
			x3_s5   <= x3_s4;    x4_s5   <= p4[2*Q_W-1:Q_W];

			quad_s6 <= quad_s5;  swap_s6 <= swap_s5;
			x_s6    <= x_s5;     x2_s6   <= x2_s5;
			x3_s6   <= x3_s5;    x4_s6   <= x4_s5;
			x5_s6   <= p5[2*Q_W-1:Q_W];

			quad_s7 <= quad_s6;  swap_s7 <= swap_s6;
			x_s7    <= x_s6;     x2_s7   <= x2_s6;
			x3_s7   <= x3_s6;    x4_s7   <= x4_s6;
			x5_s7   <= x5_s6;    x6_s7   <= p6[2*Q_W-1:Q_W];

			quad_s8 <= quad_s7;  swap_s8 <= swap_s7;
			x_s8    <= x_s7;     x2_s8   <= x2_s7;
			for (int i = 0; i < NCDIV; i++) begin
				pw_s8[i] <= pw7[i];
				q0_s8[i] <= q0[i];
			end

			quad_s9 <= quad_s8;  swap_s9 <= swap_s8;
			x_s9    <= x_s8;     x2_s9   <= x2_s8;
			for (int i = 0; i < NCDIV; i++) begin
				dq_s9[i] <= dq[i];
			end

			quad_s10 <= quad_s9; swap_s10 <= swap_s9;
			sp_s10   <= UNIT_W'(x_s9) - UNIT_W'(dq_s9[0]) + UNIT_W'(dq_s9[2]);
			cp_s10   <= ONE_Q - UNIT_W'(x2_s9 >> 1) + UNIT_W'(dq_s9[1])
				- UNIT_W'(dq_s9[3]);

			s_s11    <= s_sel;
			c_s11    <= c_sel;
			side_s11 <= side_n;
		end
	end

	// stages 12..18: ratio dividers
	logic [Q_BITS-1:0] quo_tan, quo_csc, quo_sec, quo_cot;
	logic              ovf_tan, ovf_csc, ovf_sec, ovf_cot;

	trd_div u_div_tan (.clk, .en, .num(s_s11), .den(c_s11), .quo(quo_tan), .ovf(ovf_tan));
	trd_div u_div_csc (.clk, .en, .num(ONE_Q), .den(s_s11), .quo(quo_csc), .ovf(ovf_csc));
	trd_div u_div_sec (.clk, .en, .num(ONE_Q), .den(c_s11), .quo(quo_sec), .ovf(ovf_sec));
	trd_div u_div_cot (.clk, .en, .num(c_s11), .den(s_s11), .quo(quo_cot), .ovf(ovf_cot));

	side_t side_d [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s11;
			for (int i = 1; i < DIV_STAGES; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// output stage: saturate and apply quadrant signs
	function automatic logic [RATIO_W-1:0] sign_ratio(logic [Q_BITS-1:0] q, logic sat,
		logic neg);
		logic [RATIO_W-1:0] m;
		m = {1'b0, sat ? RATIO_LIMIT : q};
		return neg ? -m : m;
	endfunction

	function automatic logic [TRIG_W-1:0] sign_trig(logic [TRIG_MAG_W-1:0] mag, logic neg);
		logic [TRIG_W-1:0] m;
		m = {1'b0, mag};
		return neg ? -m : m;
	endfunction

	side_t             sd;
	logic              tneg;
	logic [TRIG_W-1:0]  sin_q, cos_q;
	logic [RATIO_W-1:0] tan_q, csc_q, sec_q, cot_q;
	logic [FLAG_W-1:0]  flags_q;

	assign sd   = side_d[DIV_STAGES-1];
	assign tneg = sd.sneg ^ sd.cneg;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= sign_trig(sd.sin_mag, sd.sneg);
			cos_q <= sign_trig(sd.cos_mag, sd.cneg);
			tan_q <= sign_ratio(quo_tan, ovf_tan, tneg);
			csc_q <= sign_ratio(quo_csc, ovf_csc, sd.sneg);
			sec_q <= sign_ratio(quo_sec, ovf_sec, sd.cneg);
			cot_q <= sign_ratio(quo_cot, ovf_cot, tneg);
			flags_q[FLAG_TAN] <= ovf_tan;
			flags_q[FLAG_CSC] <= ovf_csc;
			flags_q[FLAG_SEC] <= ovf_sec;
			flags_q[FLAG_COT] <= ovf_cot;
		end
	end

	assign ratios.valid            = vld_q[PIPE_DEPTH-1];
	assign ratios.sine_value       = $signed(sin_q);
	assign ratios.cosine_value     = $signed(cos_q);
	assign ratios.tangent_value    = $signed(tan_q);
	assign ratios.cosecant_value   = $signed(csc_q);
	assign ratios.secant_value     = $signed(sec_q);
	assign ratios.cotangent_value  = $signed(cot_q);
	assign ratios.saturation_flags = flags_q;

	a_sin_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ratios.valid && (ratios.sine_value == '0) |-> ratios.saturation_flags[FLAG_CSC])
		else $error("zero sine without cosecant flag");

	a_cos_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ratios.valid && (ratios.cosine_value == '0) |-> ratios.saturation_flags[FLAG_SEC])
		else $error("zero cosine without secant flag");

	a_tan_cot_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ratios.valid |-> !(ratios.saturation_flags[FLAG_TAN]
			&& ratios.saturation_flags[FLAG_COT]))
		else $error("tangent and cotangent both saturated");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ratios.valid |-> angle.ready)
		else $error("input stalled with empty output");

endmodule
`default_nettype wire
